FILE: rtl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// Holds the request and response payloads, the element kinds and the cell controls.
// Depends on nothing.
package wgm_pkg;

   localparam int MASK_LEN_DEFAULT = 32;

   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_MASK    = 2'd1,
      CMD_SUBJECT = 2'd2,
      CMD_END     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_LIT  = 2'd0,
      KIND_ANY  = 2'd1,
      KIND_STAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_STEP,
      ACT_RESTART
   } act_mode_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic matched;
      logic mask_overflow;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } elem_type;

   typedef struct packed {
      logic in_use;
      logic wr_a;
      logic wr_b;
      logic show_a;
      logic origin;
   } cell_ctrl_type;

   typedef struct packed {
      elem_type     elem_a;
      elem_type     elem_b;
      act_mode_type mode;
      logic [7:0]   sym;
   } cell_bcast_type;

endpackage

FILE: rtl/wgm_cell.sv
// One mask position of the matcher chain: a stored element and its active bit.
// Passes star closure and match advance to its right neighbor each cycle.
// Depends on wgm_pkg.
module wgm_cell
   import wgm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctrl,
   input  cell_bcast_type bcast,
   input  logic           carry_in,
   input  logic           adv_in,
   output logic           carry_out,
   output logic           adv_out,
   output logic           closed
);

   elem_type elem_ff;
   logic     act_ff;
   logic     act_in;
   elem_type elem_eff;
   logic     valid_eff;
   logic     hit;

   assign valid_eff = ctrl.in_use | ctrl.show_a;
   assign elem_eff  = ctrl.show_a ? bcast.elem_a : elem_ff;
   assign closed    = act_ff | carry_in;
   assign carry_out = closed & valid_eff & (elem_eff.kind == KIND_STAR);
   assign hit       = (elem_eff.kind == KIND_ANY) |
                      ((elem_eff.kind == KIND_LIT) & (elem_eff.value == bcast.sym));
   assign adv_out   = closed & valid_eff & hit;

   always_comb begin
      unique case (bcast.mode)
         ACT_STEP:    act_in = carry_out | adv_in;
         ACT_RESTART: act_in = ctrl.origin;
         default:     act_in = act_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ctrl.origin;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_a) begin
         elem_ff <= bcast.elem_a;
      end else if (ctrl.wr_b) begin
         elem_ff <= bcast.elem_b;
      end
   end

endmodule

FILE: rtl/wildcard_glob_matcher_unit.sv
// Top level of the case-insensitive wildcard glob matcher.
// Holds the mask loader, the row of wgm_cell instances and the response register.
// Depends on wgm_pkg and wgm_cell.
//
// Usage: send a clear request, then mask bytes (cmd 1), then subject bytes (cmd 2),
// then an end request (cmd 3). Only the end request produces a response, carrying
// matched and mask_overflow. The mask stays loaded after an end request, so further
// subjects may follow at once; a clear request empties it.
// One request is accepted in every cycle in which req_stall is low. Each subject byte
// updates the whole row of cells in the cycle it is accepted, with star closure
// rippling through the row, so the MASK_LEN cells set the clock period, not the request rate.
// The response appears in the response register in the cycle after the end request is
// accepted. req_stall is high only while a response is held and rsp_stall is high;
// a held response that the receiver stalls blocks every request until it is taken.
// Reset empties the mask, clears the flags and leaves only position zero active.
// A mask longer than MASK_LEN elements sets mask_overflow and forces matched low
// until the next clear.
module wildcard_glob_matcher_unit
   import wgm_pkg::*;
#(
   parameter int MASK_LEN = MASK_LEN_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int LW = $clog2(MASK_LEN + 1);

   function automatic logic [7:0] fold(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   logic [LW-1:0]   len_ff, len_in, len_eff;
   logic            esc_ff, esc_in;
   logic            ovf_ff, ovf_in;
   logic            started_ff, started_in;
   logic            act_end_ff, act_end_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic            accept;
   logic [7:0]      sym;
   logic            do_mask;
   logic            flush;
   logic            a_req, b_req;
   logic            room_a, room_b;
   logic            a_en, b_en;
   logic            ovf_add;
   logic            ovf_now;
   elem_type        elem_a, elem_b;
   cell_bcast_type  bcast;
   logic [MASK_LEN:0] carry;
   logic [MASK_LEN:0] adv;
   logic [MASK_LEN:0] closed_vec;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign sym       = fold(req_data.symbol);
   assign do_mask   = accept & (req_data.cmd == CMD_MASK) & ~started_ff;
   assign flush     = accept & ~started_ff & esc_ff &
                      ((req_data.cmd == CMD_SUBJECT) | (req_data.cmd == CMD_END));

   always_comb begin
      a_req        = 1'b0;
      b_req        = 1'b0;
      esc_in       = esc_ff;
      elem_a.kind  = KIND_LIT;
      elem_a.value = sym;
      elem_b.kind  = KIND_LIT;
      elem_b.value = sym;
      if (flush) begin
         a_req        = 1'b1;
         esc_in       = 1'b0;
         elem_a.value = CHAR_BACKSLASH;
      end else if (do_mask) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            a_req  = 1'b1;
            if (sym != CHAR_QUESTION && sym != CHAR_STAR) begin
               elem_a.value = CHAR_BACKSLASH;
               if (sym == CHAR_BACKSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  b_req = 1'b1;
               end
            end
         end else begin
            priority if (sym == CHAR_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (sym == CHAR_STAR) begin
               a_req        = 1'b1;
               elem_a.kind  = KIND_STAR;
               elem_a.value = 8'h00;
            end else if (sym == CHAR_QUESTION) begin
               a_req        = 1'b1;
               elem_a.kind  = KIND_ANY;
               elem_a.value = 8'h00;
            end else begin
               a_req = 1'b1;
            end
         end
      end
   end

   assign room_a  = len_ff < LW'(MASK_LEN);
   assign room_b  = ({1'b0, len_ff} + (LW+1)'(1)) < (LW+1)'(MASK_LEN);
   assign a_en    = a_req & room_a;
   assign b_en    = b_req & room_b;
   assign ovf_add = (a_req & ~room_a) | (b_req & ~room_b);
   assign ovf_now = ovf_ff | (flush & ~room_a);
   assign len_eff = len_ff + LW'(flush & a_en);

   always_comb begin
      bcast.elem_a = elem_a;
      bcast.elem_b = elem_b;
      bcast.sym    = sym;
      bcast.mode   = ACT_HOLD;
      if (accept) begin
         unique case (req_data.cmd)
            CMD_CLEAR:   bcast.mode = ACT_RESTART;
            CMD_MASK:    bcast.mode = ACT_HOLD;
            CMD_SUBJECT: bcast.mode = ACT_STEP;
            CMD_END:     bcast.mode = ACT_RESTART;
         endcase
      end
   end

   assign carry[0] = 1'b0;
   assign adv[0]   = 1'b0;

   for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
      cell_ctrl_type ctrl;

      assign ctrl.in_use = LW'(i) < len_ff;
      assign ctrl.wr_a   = a_en & (LW'(i) == len_ff);
      assign ctrl.wr_b   = b_en & ((LW+1)'(i) == ({1'b0, len_ff} + (LW+1)'(1)));
      assign ctrl.show_a = flush & ctrl.wr_a;
      assign ctrl.origin = (i == 0);

      wgm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .bcast     (bcast),
         .carry_in  (carry[i]),
         .adv_in    (adv[i]),
         .carry_out (carry[i+1]),
         .adv_out   (adv[i+1]),
         .closed    (closed_vec[i])
      );
   end

   assign closed_vec[MASK_LEN] = act_end_ff | carry[MASK_LEN];

   always_comb begin
      unique case (bcast.mode)
         ACT_STEP:    act_end_in = adv[MASK_LEN];
         ACT_RESTART: act_end_in = 1'b0;
         default:     act_end_in = act_end_ff;
      endcase
   end

   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      started_in = started_ff;
      if (accept) begin
         len_in = len_ff + LW'(a_en) + LW'(b_en);
         ovf_in = ovf_ff | ovf_add;
         unique case (req_data.cmd)
            CMD_CLEAR: begin
               len_in     = '0;
               ovf_in     = 1'b0;
               started_in = 1'b0;
            end
            CMD_MASK:    started_in = started_ff;
            CMD_SUBJECT: started_in = 1'b1;
            CMD_END:     started_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         esc_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         started_ff   <= 1'b0;
         act_end_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         esc_ff     <= (accept && req_data.cmd == CMD_CLEAR) ? 1'b0 : esc_in;
         ovf_ff     <= ovf_in;
         started_ff <= started_in;
         act_end_ff <= act_end_in;
         if (accept && req_data.cmd == CMD_END) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_END) begin
         rsp_ff.matched       <= ~ovf_now & closed_vec[len_eff];
         rsp_ff.mask_overflow <= ovf_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
